### hw/rtl/lbmc_pkg.sv
// lbmc_pkg: shared types, constants and fixed-point helpers for the d2q9 bgk collision core
// no dependencies; used by lbmc_moments, lbmc_lane and lbm_d2q9_bgk_collision_core
package lbmc_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = DATA_WIDTH - 4;
  localparam int OMEGA_W    = DATA_WIDTH - 1;
  localparam int WIDE_W     = 72;
  localparam int USQ_W      = 37;
  localparam int NDIR       = 9;
  localparam int PIPE_DEPTH = 9;

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic signed [WIDE_W-1:0]     wide_t;
  typedef logic signed [USQ_W-1:0]      usq_t;
  typedef logic        [OMEGA_W-1:0]    omega_t;

  typedef struct packed {
    word_t pop_rest;
    word_t pop_east;
    word_t pop_north;
    word_t pop_west;
    word_t pop_south;
    word_t pop_northeast;
    word_t pop_northwest;
    word_t pop_southwest;
    word_t pop_southeast;
    word_t vel_x;
    word_t vel_y;
  } in_item_t;

  typedef struct packed {
    word_t post_rest;
    word_t post_east;
    word_t post_north;
    word_t post_west;
    word_t post_south;
    word_t post_northeast;
    word_t post_northwest;
    word_t post_southwest;
    word_t post_southeast;
    word_t density;
  } out_item_t;

  // lattice directions: rest, e, n, w, s, ne, nw, sw, se
  localparam int DIR_X [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_Y [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  localparam int DIR_W [NDIR] = '{0, 1, 1, 1, 1, 2, 2, 2, 2};

  localparam wide_t ONE_W   = wide_t'(1) <<< FRAC_BITS;
  localparam wide_t HALF_W  = wide_t'(1) <<< (FRAC_BITS - 1);
  localparam wide_t SAT_HI  = (wide_t'(1) <<< (DATA_WIDTH - 1)) - wide_t'(1);
  localparam wide_t SAT_LO  = -SAT_HI - wide_t'(1);
  localparam wide_t W_REST  = (ONE_W * 4 + 4) / 9;
  localparam wide_t W_AXIS  = (ONE_W + 4) / 9;
  localparam wide_t W_DIAG  = (ONE_W + 18) / 36;

  localparam omega_t OMEGA_RESET = omega_t'(5) << (FRAC_BITS - 1);

  function automatic word_t sat(input wide_t v);
    word_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[DATA_WIDTH-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[DATA_WIDTH-1:0];
    end else begin
      r = v[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

  // round half up, drop the fraction bits
  function automatic wide_t rnd_frac(input wide_t v);
    return (v + HALF_W) >>> FRAC_BITS;
  endfunction

  function automatic wide_t rnd_half(input wide_t v);
    return (v + wide_t'(1)) >>> 1;
  endfunction

  function automatic word_t weight(input logic [1:0] sel);
    word_t r;
    case (sel)
      2'd0:    r = W_REST[DATA_WIDTH-1:0];
      2'd1:    r = W_AXIS[DATA_WIDTH-1:0];
      default: r = W_DIAG[DATA_WIDTH-1:0];
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/lbm_d2q9_bgk_collision_core.sv
// d2q9 bgk collision core: nine direction lanes plus shared moments, merged into one result
// the vld_q shift register carries the start beat to the result strobe; one node per cycle sustained,
// set by the fully pipelined lanes; busy never rises
// the receiver cannot stall: each result is shown for exactly one cycle
// async active-low reset clears the valid pipeline and loads omega = 2.5
// depends on lbmc_pkg, lbmc_moments, lbmc_lane
module lbm_d2q9_bgk_collision_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  lbmc_pkg::in_item_t  item_i,
  output logic                result_valid_o,
  output lbmc_pkg::out_item_t result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  lbmc_pkg::omega_t    cfg_data_i
);

  lbmc_pkg::omega_t omega_q, omega_d;
  logic [lbmc_pkg::PIPE_DEPTH-1:0] vld_q, vld_d;
  lbmc_pkg::out_item_t result_q, result_d;
  lbmc_pkg::word_t pops [lbmc_pkg::NDIR];
  lbmc_pkg::word_t posts [lbmc_pkg::NDIR];
  lbmc_pkg::usq_t  usq;
  lbmc_pkg::word_t rho_mid, rho_end;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  assign pops[0] = item_i.pop_rest;
  assign pops[1] = item_i.pop_east;
  assign pops[2] = item_i.pop_north;
  assign pops[3] = item_i.pop_west;
  assign pops[4] = item_i.pop_south;
  assign pops[5] = item_i.pop_northeast;
  assign pops[6] = item_i.pop_northwest;
  assign pops[7] = item_i.pop_southwest;
  assign pops[8] = item_i.pop_southeast;

  lbmc_moments u_moments (
    .clk_i     (clk_i),
    .item_i    (item_i),
    .usq_o     (usq),
    .rho_mid_o (rho_mid),
    .rho_end_o (rho_end)
  );

  for (genvar k = 0; k < lbmc_pkg::NDIR; k++) begin : g_lane
    lbmc_lane #(
      .CX   (lbmc_pkg::DIR_X[k]),
      .CY   (lbmc_pkg::DIR_Y[k]),
      .WSEL (lbmc_pkg::DIR_W[k])
    ) u_lane (
      .clk_i   (clk_i),
      .f_i     (pops[k]),
      .ux_i    (item_i.vel_x),
      .uy_i    (item_i.vel_y),
      .usq_i   (usq),
      .rho_i   (rho_mid),
      .omega_i (omega_q),
      .post_o  (posts[k])
    );
  end

  always_comb begin
    omega_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : omega_q;
    vld_d   = {vld_q[lbmc_pkg::PIPE_DEPTH-2:0], start && !busy};
    result_d.post_rest      = posts[0];
    result_d.post_east      = posts[1];
    result_d.post_north     = posts[2];
    result_d.post_west      = posts[3];
    result_d.post_south     = posts[4];
    result_d.post_northeast = posts[5];
    result_d.post_northwest = posts[6];
    result_d.post_southwest = posts[7];
    result_d.post_southeast = posts[8];
    result_d.density        = rho_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      omega_q <= lbmc_pkg::OMEGA_RESET;
      vld_q   <= '0;
    end else begin
      omega_q <= omega_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_valid_o = vld_q[lbmc_pkg::PIPE_DEPTH-1];
  assign result_o       = result_q;

endmodule

### hw/rtl/lbmc_moments.sv
// lbmc_moments: density sum and squared velocity magnitude shared by all lanes
// depends on lbmc_pkg
module lbmc_moments (
  input  logic             clk_i,
  input  lbmc_pkg::in_item_t item_i,
  output lbmc_pkg::usq_t   usq_o,
  output lbmc_pkg::word_t  rho_mid_o,
  output lbmc_pkg::word_t  rho_end_o
);

  lbmc_pkg::word_t rho_q [8];
  logic signed [63:0] ux2p_q, ux2p_d, uy2p_q, uy2p_d;
  lbmc_pkg::usq_t  usq_q, usq_d;
  lbmc_pkg::wide_t sum;

  always_comb begin
    sum = lbmc_pkg::wide_t'(item_i.pop_rest) + lbmc_pkg::wide_t'(item_i.pop_east)
        + lbmc_pkg::wide_t'(item_i.pop_north) + lbmc_pkg::wide_t'(item_i.pop_west)
        + lbmc_pkg::wide_t'(item_i.pop_south) + lbmc_pkg::wide_t'(item_i.pop_northeast)
        + lbmc_pkg::wide_t'(item_i.pop_northwest) + lbmc_pkg::wide_t'(item_i.pop_southwest)
        + lbmc_pkg::wide_t'(item_i.pop_southeast);
    ux2p_d = 64'(item_i.vel_x) * 64'(item_i.vel_x);
    uy2p_d = 64'(item_i.vel_y) * 64'(item_i.vel_y);
    usq_d  = lbmc_pkg::usq_t'(lbmc_pkg::rnd_frac(lbmc_pkg::wide_t'(ux2p_q))
           + lbmc_pkg::rnd_frac(lbmc_pkg::wide_t'(uy2p_q)));
  end

  always_ff @(posedge clk_i) begin
    rho_q[0] <= lbmc_pkg::sat(sum);
    for (int i = 1; i < 8; i++) begin
      rho_q[i] <= rho_q[i-1];
    end
    ux2p_q <= ux2p_d;
    uy2p_q <= uy2p_d;
    usq_q  <= usq_d;
  end

  assign usq_o     = usq_q;
  assign rho_mid_o = rho_q[2];
  assign rho_end_o = rho_q[7];

endmodule

### hw/rtl/lbmc_lane.sv
// lbmc_lane: equilibrium and relaxation pipeline for one lattice direction
// depends on lbmc_pkg; usq and rho come from lbmc_moments
module lbmc_lane #(
  parameter int CX   = 0,
  parameter int CY   = 0,
  parameter int WSEL = 0
) (
  input  logic            clk_i,
  input  lbmc_pkg::word_t f_i,
  input  lbmc_pkg::word_t ux_i,
  input  lbmc_pkg::word_t uy_i,
  input  lbmc_pkg::usq_t  usq_i,
  input  lbmc_pkg::word_t rho_i,
  input  lbmc_pkg::omega_t omega_i,
  output lbmc_pkg::word_t post_o
);

  localparam int DATA_W_DIFF = lbmc_pkg::DATA_WIDTH + 1;

  lbmc_pkg::word_t f_q [8];
  lbmc_pkg::word_t cu_q, cu2_q, cu_d;
  logic signed [63:0] cusqp_q, cusqp_d;
  lbmc_pkg::word_t poly_q, poly_d;
  logic signed [63:0] rpp_q, rpp_d;
  lbmc_pkg::word_t rp_q, rp_d;
  logic signed [63:0] wp_q, wp_d;
  logic signed [DATA_W_DIFF-1:0] diff_q, diff_d;
  logic signed [64:0] prod_q, prod_d;
  lbmc_pkg::wide_t xterm, yterm, cusq;

  always_comb begin
    xterm = (CX > 0) ? lbmc_pkg::wide_t'(ux_i) :
            (CX < 0) ? -lbmc_pkg::wide_t'(ux_i) : '0;
    yterm = (CY > 0) ? lbmc_pkg::wide_t'(uy_i) :
            (CY < 0) ? -lbmc_pkg::wide_t'(uy_i) : '0;
    cu_d    = lbmc_pkg::sat(xterm + yterm);
    cusqp_d = 64'(cu_q) * 64'(cu_q);
    cusq    = lbmc_pkg::rnd_frac(lbmc_pkg::wide_t'(cusqp_q));
    poly_d  = lbmc_pkg::sat(lbmc_pkg::ONE_W + lbmc_pkg::wide_t'(3) * lbmc_pkg::wide_t'(cu2_q)
            + lbmc_pkg::rnd_half(lbmc_pkg::wide_t'(9) * cusq)
            - lbmc_pkg::rnd_half(lbmc_pkg::wide_t'(3) * lbmc_pkg::wide_t'(usq_i)));
    rpp_d   = 64'(rho_i) * 64'(poly_q);
    rp_d    = lbmc_pkg::sat(lbmc_pkg::rnd_frac(lbmc_pkg::wide_t'(rpp_q)));
    wp_d    = 64'(rp_q) * 64'(lbmc_pkg::weight(2'(WSEL)));
    diff_d  = DATA_W_DIFF'(lbmc_pkg::sat(lbmc_pkg::rnd_frac(lbmc_pkg::wide_t'(wp_q))))
            - DATA_W_DIFF'(f_q[5]);
    prod_d  = 65'($signed({1'b0, omega_i})) * 65'(diff_q);
  end

  always_ff @(posedge clk_i) begin
    f_q[0] <= f_i;
    for (int i = 1; i < 8; i++) begin
      f_q[i] <= f_q[i-1];
    end
    cu_q    <= cu_d;
    cu2_q   <= cu_q;
    cusqp_q <= cusqp_d;
    poly_q  <= poly_d;
    rpp_q   <= rpp_d;
    rp_q    <= rp_d;
    wp_q    <= wp_d;
    diff_q  <= diff_d;
    prod_q  <= prod_d;
  end

  assign post_o = lbmc_pkg::sat(lbmc_pkg::wide_t'(f_q[7])
                + lbmc_pkg::rnd_frac(lbmc_pkg::wide_t'(prod_q)));

endmodule
